>>> rtl/particle_resampling_wheel_defines.svh
// ----------------------------------------------------------------------------
// Resampling wheel assertion macros
// Shared concurrent assertion forms for the resampling wheel RTL.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_RESAMPLING_WHEEL_DEFINES_SVH
`define PARTICLE_RESAMPLING_WHEEL_DEFINES_SVH

// same-cycle implication
`define PRW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PRW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/prw_pkg.sv
// ----------------------------------------------------------------------------
// Resampling wheel package
// Widths, codes, sequencer states and shared types of the resampling wheel.
// ----------------------------------------------------------------------------
package prw_pkg;

   localparam int MAX_PARTICLES = 128;
   localparam int WEIGHT_BITS   = 16;
   localparam int RAND_W        = 16;

   localparam int IDX_W   = $clog2(MAX_PARTICLES);
   localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
   localparam int PC_W    = 8;
   localparam int FAC_W   = 9;
   localparam int CNTX_W  = (CNT_W > PC_W) ? CNT_W : PC_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = (FAC_W > PC_W) ? FAC_W : PC_W;

   localparam int SUM_W    = WEIGHT_BITS + IDX_W;
   localparam int SQ_W     = 2 * WEIGHT_BITS + IDX_W;
   localparam int SQ_LO_W  = (SQ_W + 1) / 2;
   localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
   localparam int FN_W     = FAC_W + CNT_W;
   localparam int MUL_W    = SUM_W;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int CMP_W    = FAC_W + CNT_W + SQ_W;
   localparam int ESS_SHIFT = FAC_W - 1;
   localparam int BETA_W   = 19;
   localparam int STEP_W   = CNT_W + 2;

   localparam logic [PC_W-1:0]  PC_RESET  = PC_W'(100);
   localparam logic [FAC_W-1:0] FAC_RESET = FAC_W'(128);

   localparam logic [CSR_IDX_W-1:0] CSR_PARTICLE_COUNT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RESAMPLE_FACTOR = CSR_IDX_W'(1);

   localparam logic RESULT_SUMMARY = 1'b0;
   localparam logic RESULT_DRAW    = 1'b1;

   typedef enum logic [1:0] {
      REQ_LOAD,
      REQ_START,
      REQ_DRAW,
      REQ_NONE
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_MUL,
      ST_LD_ACC,
      ST_SUM_MUL,
      ST_FN_MUL,
      ST_SQLO_MUL,
      ST_SQHI_MUL,
      ST_RHS_ACC,
      ST_LD_CMP,
      ST_ST_MUL,
      ST_ST_SET,
      ST_DR_MUL,
      ST_DR_BETA,
      ST_DR_WALK
   } state_type;

   typedef struct packed {
      logic                   en;
      logic [IDX_W-1:0]       addr;
      logic [WEIGHT_BITS-1:0] data;
   } mem_wr_type;

   // particle count in use: zero reads as one, clamped to the store depth
   function automatic logic [CNT_W-1:0] active_count(input logic [PC_W-1:0] pc);
      logic [CNTX_W-1:0] pcx;
      logic [CNTX_W-1:0] lim;
      logic [CNT_W-1:0]  n;
      pcx = CNTX_W'(pc);
      lim = CNTX_W'(MAX_PARTICLES);
      if (pcx == '0) begin
         n = CNT_W'(1);
      end else if (pcx > lim) begin
         n = CNT_W'(lim);
      end else begin
         n = CNT_W'(pcx);
      end
      return n;
   endfunction

endpackage

>>> rtl/prw_weight_mem.sv
// ----------------------------------------------------------------------------
// Resampling wheel weight store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prw_weight_mem import prw_pkg::*; (
   input  logic                   clock,
   input  mem_wr_type             wr,
   input  logic [IDX_W-1:0]       rd_addr,
   output logic [WEIGHT_BITS-1:0] rd_data
);

   logic [WEIGHT_BITS-1:0] weight_ram [MAX_PARTICLES];
   logic [WEIGHT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         weight_ram[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= weight_ram[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/prw_mul_unit.sv
// ----------------------------------------------------------------------------
// Resampling wheel shared multiplier
// Unsigned multiply with a registered product, shared by every operation.
// ----------------------------------------------------------------------------
module prw_mul_unit import prw_pkg::*; (
   input  logic              clock,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/particle_resampling_wheel.sv
// Order: load LD_MUL, LD_ACC (the last load of a round runs on to LD_CMP and the
// summary); start ST_MUL, ST_SET; draw DR_MUL, DR_BETA, k walk steps (k <= 4N).
// Throughput: one word at a time, set by the single shared multiplier and the
// one-entry-per-cycle walk through the weight store read port.
// Reset: synchronous, clears control state and accumulators, loads the count
// (100) and factor (128); the weight store is not cleared.
// ----------------------------------------------------------------------------
// Particle resampling wheel
// Weight loading with effective sample size test and wheel sample drawing.
// ----------------------------------------------------------------------------
`include "particle_resampling_wheel_defines.svh"

module particle_resampling_wheel import prw_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic [WEIGHT_BITS-1:0] req_weight,
   input  logic [RAND_W-1:0]      req_rand_fraction,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_result_kind,
   output logic                   rsp_resample_needed,
   output logic [IDX_W-1:0]       rsp_best_index,
   output logic [IDX_W-1:0]       rsp_drawn_index
);

   state_type state_ff, state_in;

   logic [PC_W-1:0]        particle_count_ff, particle_count_in;
   logic [FAC_W-1:0]       resample_factor_ff, resample_factor_in;

   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [RAND_W-1:0]      rand_ff, rand_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic                   last_ff, last_in;
   logic [IDX_W-1:0]       load_count_ff, load_count_in;
   logic [SUM_W-1:0]       weight_sum_ff, weight_sum_in;
   logic [SQ_W-1:0]        square_sum_ff, square_sum_in;
   logic [WEIGHT_BITS-1:0] max_weight_ff, max_weight_in;
   logic [IDX_W-1:0]       max_position_ff, max_position_in;
   logic [IDX_W-1:0]       wheel_index_ff, wheel_index_in;
   logic [BETA_W-1:0]      wheel_beta_ff, wheel_beta_in;
   logic [STEP_W-1:0]      steps_ff, steps_in;
   logic [FN_W-1:0]        fn_ff, fn_in;
   logic [CMP_W-1:0]       lhs_ff, lhs_in;
   logic [CMP_W-1:0]       rhs_ff, rhs_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic                   rsp_need_ff, rsp_need_in;
   logic [IDX_W-1:0]       rsp_best_ff, rsp_best_in;
   logic [IDX_W-1:0]       rsp_drawn_ff, rsp_drawn_in;

   logic [CNT_W-1:0]       n;
   logic                   req_fire;
   logic                   csr_fire;
   logic                   rsp_free;
   logic                   rsp_load;
   logic [IDX_W-1:0]       load_pos;
   logic                   load_last;
   logic [STEP_W-1:0]      walk_limit;
   logic                   walk_step;
   logic [CNT_W-1:0]       idx_inc;
   logic [IDX_W-1:0]       idx_next;
   logic [BETA_W:0]        beta_sum;
   logic [MUL_W-1:0]       mul_a;
   logic [MUL_W-1:0]       mul_b;
   logic [PROD_W-1:0]      prod;
   logic [WEIGHT_BITS-1:0] rd_data;
   mem_wr_type             mem_wr;

   assign n         = active_count(particle_count_ff);
   assign req_fire  = req_valid & req_ready;
   assign csr_fire  = csr_valid & csr_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign load_pos  = (CNT_W'(load_count_ff) >= n) ? IDX_W'(n - CNT_W'(1)) : load_count_ff;
   assign load_last = (CNT_W'(load_pos) + CNT_W'(1)) >= n;

   assign walk_limit = {n, 2'b00};
   assign walk_step  = (wheel_beta_ff > BETA_W'(rd_data)) && (steps_ff < walk_limit);
   assign idx_inc    = CNT_W'(wheel_index_ff) + CNT_W'(1);
   assign idx_next   = (idx_inc >= n) ? '0 : IDX_W'(idx_inc);
   assign beta_sum   = (BETA_W+1)'(wheel_beta_ff)
                     + (BETA_W+1)'(prod[RAND_W-1 +: WEIGHT_BITS+1]);

   assign mem_wr.en   = req_fire && (req_type == REQ_LOAD);
   assign mem_wr.addr = load_pos;
   assign mem_wr.data = req_weight;

   prw_weight_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (wheel_index_in),
      .rd_data (rd_data)
   );

   prw_mul_unit u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind_type'(req_type))
                  REQ_LOAD:  state_in = ST_LD_MUL;
                  REQ_START: state_in = ST_ST_MUL;
                  REQ_DRAW:  state_in = ST_DR_MUL;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LD_MUL:   state_in = ST_LD_ACC;
         ST_LD_ACC:   state_in = last_ff ? ST_SUM_MUL : ST_IDLE;
         ST_SUM_MUL:  state_in = ST_FN_MUL;
         ST_FN_MUL:   state_in = ST_SQLO_MUL;
         ST_SQLO_MUL: state_in = ST_SQHI_MUL;
         ST_SQHI_MUL: state_in = ST_RHS_ACC;
         ST_RHS_ACC:  state_in = ST_LD_CMP;
         ST_LD_CMP:   state_in = rsp_free ? ST_IDLE : ST_LD_CMP;
         ST_ST_MUL:   state_in = ST_ST_SET;
         ST_ST_SET:   state_in = ST_IDLE;
         ST_DR_MUL:   state_in = ST_DR_BETA;
         ST_DR_BETA:  state_in = ST_DR_WALK;
         ST_DR_WALK: begin
            if (!walk_step && rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      csr_ready = 1'b0;
      rsp_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
         end
         ST_LD_MUL: begin
            mul_a = MUL_W'(weight_ff);
            mul_b = MUL_W'(weight_ff);
         end
         ST_SUM_MUL: begin
            mul_a = MUL_W'(weight_sum_ff);
            mul_b = MUL_W'(weight_sum_ff);
         end
         ST_FN_MUL: begin
            mul_a = MUL_W'(resample_factor_ff);
            mul_b = MUL_W'(n);
         end
         ST_SQLO_MUL: begin
            mul_a = MUL_W'(prod[FN_W-1:0]);
            mul_b = MUL_W'(square_sum_ff[SQ_LO_W-1:0]);
         end
         ST_SQHI_MUL: begin
            mul_a = MUL_W'(fn_ff);
            mul_b = MUL_W'(square_sum_ff[SQ_W-1 -: SQ_HI_W]);
         end
         ST_LD_CMP: begin
            rsp_load = rsp_free;
         end
         ST_ST_MUL: begin
            mul_a = MUL_W'(rand_ff);
            mul_b = MUL_W'(n);
         end
         ST_DR_MUL: begin
            mul_a = MUL_W'(rand_ff);
            mul_b = MUL_W'(max_weight_ff);
         end
         ST_DR_WALK: begin
            rsp_load = !walk_step && rsp_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // configuration
   always_comb begin
      particle_count_in  = particle_count_ff;
      resample_factor_in = resample_factor_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_PARTICLE_COUNT:  particle_count_in  = csr_data[PC_W-1:0];
            CSR_RESAMPLE_FACTOR: resample_factor_in = csr_data[FAC_W-1:0];
            default:             particle_count_in  = particle_count_ff;
         endcase
      end
   end

   // datapath
   always_comb begin
      weight_in       = weight_ff;
      rand_in         = rand_ff;
      pos_in          = pos_ff;
      last_in         = last_ff;
      load_count_in   = load_count_ff;
      weight_sum_in   = weight_sum_ff;
      square_sum_in   = square_sum_ff;
      max_weight_in   = max_weight_ff;
      max_position_in = max_position_ff;
      wheel_index_in  = wheel_index_ff;
      wheel_beta_in   = wheel_beta_ff;
      steps_in        = steps_ff;
      fn_in           = fn_ff;
      lhs_in          = lhs_ff;
      rhs_in          = rhs_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               weight_in = req_weight;
               rand_in   = req_rand_fraction;
               pos_in    = load_pos;
               last_in   = load_last;
               if (req_type == REQ_LOAD) begin
                  load_count_in = load_last ? '0
                                : IDX_W'(CNT_W'(load_pos) + CNT_W'(1));
               end
            end
         end
         ST_LD_ACC: begin
            // first load of a round restarts the accumulators
            if (pos_ff == '0) begin
               weight_sum_in = SUM_W'(weight_ff);
               square_sum_in = SQ_W'(prod[2*WEIGHT_BITS-1:0]);
            end else begin
               weight_sum_in = weight_sum_ff + SUM_W'(weight_ff);
               square_sum_in = square_sum_ff + SQ_W'(prod[2*WEIGHT_BITS-1:0]);
            end
            if (pos_ff == '0 || weight_ff > max_weight_ff) begin
               max_weight_in   = weight_ff;
               max_position_in = pos_ff;
            end
         end
         ST_FN_MUL: begin
            lhs_in = CMP_W'(prod) << ESS_SHIFT;
         end
         ST_SQLO_MUL: begin
            fn_in = prod[FN_W-1:0];
         end
         ST_SQHI_MUL: begin
            rhs_in = CMP_W'(prod);
         end
         ST_RHS_ACC: begin
            rhs_in = rhs_ff + (CMP_W'(prod) << SQ_LO_W);
         end
         ST_ST_SET: begin
            wheel_index_in = prod[RAND_W +: IDX_W];
            wheel_beta_in  = '0;
         end
         ST_DR_BETA: begin
            wheel_beta_in  = beta_sum[BETA_W] ? '1 : beta_sum[BETA_W-1:0];
            wheel_index_in = (CNT_W'(wheel_index_ff) >= n) ? '0 : wheel_index_ff;
            steps_in       = '0;
         end
         ST_DR_WALK: begin
            if (walk_step) begin
               wheel_beta_in  = wheel_beta_ff - BETA_W'(rd_data);
               wheel_index_in = idx_next;
               steps_in       = steps_ff + STEP_W'(1);
            end
         end
         default: begin
            weight_in = weight_ff;
         end
      endcase
   end

   // result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_need_in  = rsp_need_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_drawn_in = rsp_drawn_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (state_ff == ST_LD_CMP) begin
            rsp_kind_in  = RESULT_SUMMARY;
            rsp_need_in  = (square_sum_ff != '0) && (lhs_ff <= rhs_ff);
            rsp_best_in  = max_position_ff;
            rsp_drawn_in = '0;
         end else begin
            rsp_kind_in  = RESULT_DRAW;
            rsp_need_in  = 1'b0;
            rsp_best_in  = '0;
            rsp_drawn_in = wheel_index_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         particle_count_ff  <= PC_RESET;
         resample_factor_ff <= FAC_RESET;
         load_count_ff      <= '0;
         weight_sum_ff      <= '0;
         square_sum_ff      <= '0;
         max_weight_ff      <= '0;
         max_position_ff    <= '0;
         wheel_index_ff     <= '0;
         wheel_beta_ff      <= '0;
         steps_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         particle_count_ff  <= particle_count_in;
         resample_factor_ff <= resample_factor_in;
         load_count_ff      <= load_count_in;
         weight_sum_ff      <= weight_sum_in;
         square_sum_ff      <= square_sum_in;
         max_weight_ff      <= max_weight_in;
         max_position_ff    <= max_position_in;
         wheel_index_ff     <= wheel_index_in;
         wheel_beta_ff      <= wheel_beta_in;
         steps_ff           <= steps_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      weight_ff    <= weight_in;
      rand_ff      <= rand_in;
      pos_ff       <= pos_in;
      last_ff      <= last_in;
      fn_ff        <= fn_in;
      lhs_ff       <= lhs_in;
      rhs_ff       <= rhs_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_need_ff  <= rsp_need_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_drawn_ff <= rsp_drawn_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_resample_needed = rsp_need_ff;
   assign rsp_best_index      = rsp_best_ff;
   assign rsp_drawn_index     = rsp_drawn_ff;

   `PRW_ASSERT_NEXT(a_busy_after_word, req_valid && req_ready && (req_type != REQ_NONE), !req_ready, "input taken while a word is in progress")
   `PRW_ASSERT_NEXT(a_wheel_in_range, state_ff == ST_DR_BETA, CNT_W'(wheel_index_ff) < n, "wheel index outside particle range at walk start")
   `PRW_ASSERT_NOW(a_walk_bounded, state_ff == ST_DR_WALK, steps_ff <= walk_limit, "wheel walk ran past its step limit")

endmodule
